@@ src/isrt_pkg.sv @@
// ----------------------------------------------------------------------------
// isrt_pkg: shared types and codes of the in-sync replica tracker
// Input kinds, status codes, register indexes and the word layouts.
// ----------------------------------------------------------------------------
package isrt_pkg;

    localparam logic [2:0] K_ADD      = 3'd0;
    localparam logic [2:0] K_REMOVE   = 3'd1;
    localparam logic [2:0] K_PROGRESS = 3'd2;
    localparam logic [2:0] K_SELECT   = 3'd3;
    localparam logic [2:0] K_MAINT    = 3'd4;
    localparam logic [2:0] K_TICK     = 3'd5;
    // unused kind, leaves every entry as it is
    localparam logic [2:0] K_NOP      = 3'd7;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;

    localparam logic [1:0] REG_MAX_LAG     = 2'd0;
    localparam logic [1:0] REG_ACK_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_MIN_IN_SYNC = 2'd2;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] node_key;
        logic [63:0] persisted_pos;
        logic [63:0] leader_pos;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic        write_allowed;
        logic [63:0] committed_pos;
        logic [63:0] min_replica_pos;
        logic [8:0]  in_sync_count;
        logic [8:0]  replica_count;
    } t_out_word;

    // entry contents handed from cell to cell
    typedef struct packed {
        logic        valid;
        logic        in_sync;
        logic [63:0] node;
        logic [63:0] persisted;
        logic [31:0] age;
    } t_entry;

    // control broadcast to every cell during one pass
    typedef struct packed {
        logic        shift;
        logic [2:0]  kind;
        logic [63:0] key;
        logic [63:0] pos;
        logic [63:0] leader;
        logic [63:0] max_lag;
        logic [31:0] ack_timeout;
        logic        free_take;
    } t_cell_ctl;

endpackage

@@ src/isrt_if.sv @@
// ----------------------------------------------------------------------------
// isrt_if: valid/ready channel
// Carries one word of type T from a source to a sink.
// ----------------------------------------------------------------------------
interface isrt_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/isrt_cell.sv @@
// ----------------------------------------------------------------------------
// isrt_cell: one replica slot of the rotating table
// Takes the entry of its neighbor each pass cycle; the head cell applies the op.
// ----------------------------------------------------------------------------
module isrt_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_head,
    input  isrt_pkg::t_cell_ctl i_ctl,
    input  isrt_pkg::t_entry    i_prev,
    output isrt_pkg::t_entry    o_entry
);
    import isrt_pkg::*;

    t_entry r_e, n_e, w_op;
    logic [63:0] w_lag;

    // apply the operation to the entry passing the head
    always_comb begin
        w_op  = i_prev;
        w_lag = (i_ctl.leader > i_prev.persisted) ? i_ctl.leader - i_prev.persisted : 64'd0;
        if (i_prev.valid) begin
            case (i_ctl.kind)
                K_ADD: if (i_prev.node == i_ctl.key) begin
                    w_op.age = 32'd0;
                    w_op.in_sync = 1'b0;
                end
                K_REMOVE: if (i_prev.node == i_ctl.key) begin
                    w_op.valid = 1'b0;
                    w_op.in_sync = 1'b0;
                end
                K_PROGRESS: if (i_prev.node == i_ctl.key) begin
                    if (i_ctl.pos > i_prev.persisted) w_op.persisted = i_ctl.pos;
                    w_op.age = 32'd0;
                end
                K_SELECT: w_op.in_sync = (w_lag <= i_ctl.max_lag);
                K_MAINT:  w_op.in_sync = (w_lag <= i_ctl.max_lag) &&
                                         (i_prev.age <= i_ctl.ack_timeout);
                K_TICK:   if (i_prev.age != 32'hFFFF_FFFF) w_op.age = i_prev.age + 32'd1;
                default: ;
            endcase
        end else if (i_ctl.free_take) begin
            w_op.valid     = 1'b1;
            w_op.in_sync   = 1'b0;
            w_op.node      = i_ctl.key;
            w_op.persisted = 64'd0;
            w_op.age       = 32'd0;
        end
        n_e = r_e;
        if (i_ctl.shift) n_e = i_head ? w_op : i_prev;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e.valid   <= 1'b0;
            r_e.in_sync <= 1'b0;
        end else begin
            r_e.valid   <= n_e.valid;
            r_e.in_sync <= n_e.in_sync;
        end
        r_e.node      <= n_e.node;
        r_e.persisted <= n_e.persisted;
        r_e.age       <= n_e.age;
    end

    assign o_entry = r_e;
endmodule

@@ src/in_sync_replica_tracker.sv @@
// ----------------------------------------------------------------------------
// in_sync_replica_tracker: table of replicas with in-sync set and commit point
// A ring of slot cells rotates twice per word; the head applies the op.
// ----------------------------------------------------------------------------
// From accept to result: one ring turn to look up the key, one turn plus
// a fold step to apply the op, and the load into the output register.
// One word is handled at a time; a new word is taken in idle, once the last
// result is loaded, also while that result waits in the output register.
// Reset clears valid and in-sync marks of all slots at once and loads the
// register defaults; no clearing pass.
module in_sync_replica_tracker #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [63:0]          i_cfg_data,
    isrt_if.sink                 in_ch,
    isrt_if.source               out_ch
);
    import isrt_pkg::*;

    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;
    localparam logic [1:0] S_OUT = 2'd3;

    logic [63:0] r_max_lag;
    logic [31:0] r_ack;
    logic [8:0]  r_min_sync;
    logic [1:0]  r_state;
    logic [CW-1:0] r_cnt;
    t_in_word    r_in;
    logic        r_found, r_any_free;
    logic [1:0]  w_status;
    logic        r_taken;
    logic [8:0]  r_nsync, r_nvalid;
    logic [63:0] r_commit, r_minpos;
    logic        r_ovalid;
    t_out_word   r_out;
    t_out_word   w_out;
    logic        w_load;

    t_entry    w_e [TABLE_ENTRIES];
    t_cell_ctl w_ctl;
    t_entry    w_head_new;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_lag  <= 64'd0;
            r_ack      <= 32'd1000;
            r_min_sync <= 9'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MAX_LAG:     r_max_lag  <= i_cfg_data;
                REG_ACK_TIMEOUT: r_ack      <= i_cfg_data[31:0];
                REG_MIN_IN_SYNC: r_min_sync <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // broadcast control
    always_comb begin
        w_ctl.shift       = (r_state == S_SCAN) ||
                            ((r_state == S_APPLY) && (r_cnt != CW'(TABLE_ENTRIES)));
        w_ctl.kind        = (r_state == S_APPLY) ? r_in.kind : K_NOP;
        w_ctl.key         = r_in.node_key;
        w_ctl.pos         = r_in.persisted_pos;
        w_ctl.leader      = r_in.leader_pos;
        w_ctl.max_lag     = r_max_lag;
        w_ctl.ack_timeout = r_ack;
        w_ctl.free_take   = (r_state == S_APPLY) && (r_in.kind == K_ADD) && !r_found &&
                            !r_taken;
    end

    // ring of cells; cell 0 takes from the last cell and applies the op
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        isrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_head  (g == 0),
            .i_ctl   (w_ctl),
            .i_prev  (w_e[(g + TABLE_ENTRIES - 1) % TABLE_ENTRIES]),
            .o_entry (w_e[g])
        );
    end

    // entry the head wrote last cycle, as cell 0 now holds it
    assign w_head_new = w_e[0];

    // sequencer and summary fold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
        end else begin
            case (r_state)
                S_IDLE: if (in_ch.valid) begin
                    r_in       <= in_ch.data;
                    r_found    <= 1'b0;
                    r_any_free <= 1'b0;
                    r_cnt      <= '0;
                    r_state    <= S_SCAN;
                end
                S_SCAN: begin
                    // look at the entry moving into the head
                    if (w_e[TABLE_ENTRIES-1].valid &&
                        w_e[TABLE_ENTRIES-1].node == r_in.node_key) r_found <= 1'b1;
                    if (!w_e[TABLE_ENTRIES-1].valid) r_any_free <= 1'b1;
                    if (r_cnt == CW'(TABLE_ENTRIES - 1)) begin
                        r_cnt    <= '0;
                        r_taken  <= 1'b0;
                        r_nsync  <= '0;
                        r_nvalid <= '0;
                        r_commit <= '1;
                        r_minpos <= '1;
                        r_state  <= S_APPLY;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_APPLY: begin
                    if (w_ctl.free_take && !w_e[TABLE_ENTRIES-1].valid) r_taken <= 1'b1;
                    // fold the entry written last cycle into cell 0
                    if (r_cnt != '0 && w_head_new.valid) begin
                        r_nvalid <= r_nvalid + 9'd1;
                        if (w_head_new.persisted < r_minpos) r_minpos <= w_head_new.persisted;
                        if (w_head_new.in_sync) begin
                            r_nsync <= r_nsync + 9'd1;
                            if (w_head_new.persisted < r_commit)
                                r_commit <= w_head_new.persisted;
                        end
                    end
                    if (r_cnt == CW'(TABLE_ENTRIES)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_OUT: if (w_load) begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // shift during the fold tail must stop after one full turn
    // (the last APPLY cycle, cnt == TABLE_ENTRIES, only folds)

    always_comb begin
        w_status = ST_OK;
        if ((r_in.kind == K_ADD) && !r_found && !r_any_free) w_status = ST_FULL;
        if (((r_in.kind == K_REMOVE) || (r_in.kind == K_PROGRESS)) && !r_found)
            w_status = ST_UNKNOWN;
        w_out.status          = w_status;
        w_out.write_allowed   = (r_nsync >= r_min_sync);
        w_out.committed_pos   = (r_nsync == '0) ? 64'd0 : r_commit;
        w_out.min_replica_pos = (r_nvalid == '0) ? 64'd0 : r_minpos;
        w_out.in_sync_count   = r_nsync;
        w_out.replica_count   = r_nvalid;
    end

    // result register, loaded when empty or emptied this cycle
    assign w_load = (r_state == S_OUT) && (!r_ovalid || out_ch.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (out_ch.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_out;
        end
    end

    assign in_ch.ready  = (r_state == S_IDLE);
    assign out_ch.valid = r_ovalid;
    assign out_ch.data  = r_out;
endmodule

@@ src/isrt_checker.sv @@
// ----------------------------------------------------------------------------
// isrt_checker: port-level checks of the replica tracker
// Watches handshakes and result consistency.
// ----------------------------------------------------------------------------
module isrt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [8:0] out_nsync,
    input logic [8:0] out_nvalid,
    input logic [63:0] out_commit
);
    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    // stalled result keeps its counts and commit point
    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> $stable(out_nsync) && $stable(out_nvalid) &&
        $stable(out_commit)) else $error("result changed while stalled");
    // in-sync count does not exceed the count of valid entries
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> out_nsync <= out_nvalid) else $error("count mismatch");
    // empty in-sync set commits zero
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_nsync == 9'd0 |-> out_commit == 64'd0) else $error("commit");
endmodule

bind in_sync_replica_tracker isrt_checker u_isrt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_nsync  (out_ch.data.in_sync_count),
    .out_nvalid (out_ch.data.replica_count),
    .out_commit (out_ch.data.committed_pos)
);
